// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file, the only one that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is held
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hw/rtl/w6j_pkg.sv
// Types and constants for the 6j unit-argument evaluator
`timescale 1ns / 1ps
package w6j_pkg;

    localparam int MOM_W     = 10;
    localparam int FRAC_BITS = 30;
    localparam int ROOT_BITS = FRAC_BITS + 1;      // root bits resolved by the cell row
    localparam int FAC_W     = 23;                 // signed factor width
    localparam int MAG_W     = FAC_W - 1;
    localparam int QF_W      = 12;                 // denominator factor magnitude
    localparam int PAIR_W    = 24;
    localparam int PROD_W    = 2 * PAIR_W;
    localparam int Q_W       = 72;
    localparam int Q4_W      = 70;
    localparam int M_W       = Q4_W + ROOT_BITS;
    localparam int X_W       = Q4_W + 34;
    localparam int VAL_W     = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_RULE = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef logic signed [FAC_W-1:0] fac_t;

    typedef struct packed {
        status_t status;
        logic    zero;
        logic    neg;
        logic    sat;
    } meta_t;

    typedef struct packed {
        logic                   valid;
        meta_t                  meta;
        logic [3:0][MAG_W-1:0]  nmag;
        logic [5:0][QF_W-1:0]   qmag;
    } front_t;

    typedef struct packed {
        logic                   valid;
        meta_t                  meta;
        logic [X_W-1:0]         x;
        logic [M_W-1:0]         m;
        logic [ROOT_BITS-1:0]   u;
        logic [Q4_W-1:0]        q4;
    } lane_t;

endpackage

// File: hw/rtl/w6j_front.sv
// Argument checks, formula selection and factor setup stage
`timescale 1ns / 1ps
module w6j_front import w6j_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [MOM_W-1:0] mom_a,
    input  logic [MOM_W-1:0] mom_b,
    input  logic [MOM_W-1:0] mom_c,
    input  logic [MOM_W-1:0] mom_d,
    input  logic [MOM_W-1:0] mom_f,
    output front_t           front_o
);

    logic signed [12:0] a, b, c, d, f, cd, ab;
    logic signed [23:0] bx, dx, fx, l_val;
    fac_t  nf [4];
    fac_t  df [6];
    logic  par, lneg, tri_fail;
    logic  [3:0] n_zero, n_neg;
    logic  [5:0] d_zero, d_neg;
    front_t front_next, front_reg;

    always_comb begin
        a  = 13'(mom_a);
        b  = 13'(mom_b);
        c  = 13'(mom_c);
        d  = 13'(mom_d);
        f  = 13'(mom_f);
        cd = c - d;
        ab = a - b;
        bx = 24'(b);
        dx = 24'(d);
        fx = 24'(f);
        l_val = bx * (bx + 24'sd1) + dx * (dx + 24'sd1) - fx * (fx + 24'sd1);

        tri_fail = ((a > c) ? (a - c) : (c - a)) > f ||
                   ((b > d) ? (b - d) : (d - b)) > f ||
                   (a + c) < f || (b + d) < f || cd == 13'sd2;

        par  = 1'b0;
        lneg = 1'b0;
        if (cd == 13'sd0) begin
            if (ab == 13'sd0) begin
                nf[0] = FAC_W'(l_val); nf[1] = FAC_W'(l_val);
                nf[2] = FAC_W'(1);     nf[3] = FAC_W'(1);
                df[0] = FAC_W'(b); df[1] = FAC_W'(b+1); df[2] = FAC_W'(2*b+1);
                df[3] = FAC_W'(d); df[4] = FAC_W'(2*d+1); df[5] = FAC_W'(d+1);
                par  = 1'b1;
                lneg = l_val[23];
            end else if (ab == 13'sd1) begin
                nf[0] = FAC_W'(f+d+b+2); nf[1] = FAC_W'(f+b-d+1);
                nf[2] = FAC_W'(b+d-f+1); nf[3] = FAC_W'(f+d-b);
                df[0] = FAC_W'(2*b+1); df[1] = FAC_W'(b+1); df[2] = FAC_W'(2*b+3);
                df[3] = FAC_W'(d); df[4] = FAC_W'(d+1); df[5] = FAC_W'(2*d+1);
            end else begin
                nf[0] = FAC_W'(f+b+d+1); nf[1] = FAC_W'(d+b-f);
                nf[2] = FAC_W'(f+b-d);   nf[3] = FAC_W'(f+d-b+1);
                df[0] = FAC_W'(2*b+1); df[1] = FAC_W'(b); df[2] = FAC_W'(2*b-1);
                df[3] = FAC_W'(d); df[4] = FAC_W'(2*d+1); df[5] = FAC_W'(d+1);
                par = 1'b1;
            end
        end else if (cd == 13'sd1) begin
            if (ab == 13'sd0) begin
                nf[0] = FAC_W'(f+d+b+2); nf[1] = FAC_W'(b+d-f+1);
                nf[2] = FAC_W'(f+d-b+1); nf[3] = FAC_W'(f+b-d);
                df[0] = FAC_W'(b); df[1] = FAC_W'(2*b+1); df[2] = FAC_W'(b+1);
                df[3] = FAC_W'(2*d+1); df[4] = FAC_W'(d+1); df[5] = FAC_W'(2*d+3);
            end else if (ab == 13'sd1) begin
                nf[0] = FAC_W'(f+d+b+3); nf[1] = FAC_W'(f+b+d+2);
                nf[2] = FAC_W'(b+d-f+2); nf[3] = FAC_W'(b+d-f+1);
                df[0] = FAC_W'(2*b+3); df[1] = FAC_W'(b+1); df[2] = FAC_W'(2*b+1);
                df[3] = FAC_W'(2*d+3); df[4] = FAC_W'(d+1); df[5] = FAC_W'(2*d+1);
            end else begin
                nf[0] = FAC_W'(f+b-d);   nf[1] = FAC_W'(f+b-d-1);
                nf[2] = FAC_W'(f+d-b+2); nf[3] = FAC_W'(f+d-b+1);
                df[0] = FAC_W'(2*b+1); df[1] = FAC_W'(b); df[2] = FAC_W'(2*b-1);
                df[3] = FAC_W'(d+1); df[4] = FAC_W'(2*d+1); df[5] = FAC_W'(2*d+3);
            end
        end else begin
            if (ab == 13'sd0) begin
                nf[0] = FAC_W'(f+b+d+1); nf[1] = FAC_W'(f+b-d+1);
                nf[2] = FAC_W'(f+d-b);   nf[3] = FAC_W'(b+d-f);
                df[0] = FAC_W'(b); df[1] = FAC_W'(2*b+1); df[2] = FAC_W'(b+1);
                df[3] = FAC_W'(d); df[4] = FAC_W'(2*d+1); df[5] = FAC_W'(2*d-1);
                par = 1'b1;
            end else if (ab == 13'sd1) begin
                nf[0] = FAC_W'(f+d-b);   nf[1] = FAC_W'(f+d-b-1);
                nf[2] = FAC_W'(f+b-d+2); nf[3] = FAC_W'(f+b-d+1);
                df[0] = FAC_W'(2*b+1); df[1] = FAC_W'(b+1); df[2] = FAC_W'(2*b+3);
                df[3] = FAC_W'(2*d-1); df[4] = FAC_W'(d); df[5] = FAC_W'(2*d+1);
            end else begin
                nf[0] = FAC_W'(f+b+d+1); nf[1] = FAC_W'(f+b+d);
                nf[2] = FAC_W'(b+d-f);   nf[3] = FAC_W'(b+d-1-f);
                df[0] = FAC_W'(2*b+1); df[1] = FAC_W'(b); df[2] = FAC_W'(2*b-1);
                df[3] = FAC_W'(d); df[4] = FAC_W'(2*d-1); df[5] = FAC_W'(2*d+1);
            end
        end

        front_next = '0;
        for (int i = 0; i < 4; i++) begin
            n_zero[i] = (nf[i] == '0);
            n_neg[i]  = nf[i][FAC_W-1];
            front_next.nmag[i] = n_neg[i] ? MAG_W'(-nf[i]) : MAG_W'(nf[i]);
        end
        for (int i = 0; i < 6; i++) begin
            d_zero[i] = (df[i] == '0);
            d_neg[i]  = df[i][FAC_W-1];
            front_next.qmag[i] = d_neg[i] ? QF_W'(-df[i]) : QF_W'(df[i]);
        end

        front_next.valid     = in_valid;
        front_next.meta.sat  = 1'b0;
        front_next.meta.neg  = lneg ^ a[0] ^ c[0] ^ f[0] ^ par;
        front_next.meta.zero = 1'b1;
        if (tri_fail)
            front_next.meta.status = ST_RULE;
        else if (|d_zero)
            front_next.meta.status = ST_BAD;
        else if (|n_zero)
            front_next.meta.status = ST_OK;
        else if ((^n_neg) != (^d_neg))
            front_next.meta.status = ST_BAD;
        else begin
            front_next.meta.status = ST_OK;
            front_next.meta.zero   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (adv) begin
            front_reg <= front_next;
        end
    end

    assign front_o = front_reg;

endmodule

// File: hw/rtl/w6j_mult.sv
// Product stages: numerator and 4x denominator, saturation check, root seed
`timescale 1ns / 1ps
module w6j_mult import w6j_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  front_t front_i,
    output lane_t  lane_o
);

    logic [3:0] v_reg;
    meta_t      m1_reg, m2_reg, m3_reg, m4_reg;
    logic [PAIR_W-1:0] n02_reg, n13_reg, q01_reg, q23_reg, q45_reg, q45b_reg;
    logic [PROD_W-1:0] nn2_reg, nn3_reg, nn4_reg, qa_reg, qlo_reg, qhi_reg;
    logic [Q_W-1:0]    q_reg;
    lane_t             lane_next, lane_reg;
    logic [Q_W+1:0]    q4_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[2:0], front_i.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // pair products
            m1_reg  <= front_i.meta;
            n02_reg <= PAIR_W'(front_i.nmag[0]) * PAIR_W'(front_i.nmag[2]);
            n13_reg <= PAIR_W'(front_i.nmag[1]) * PAIR_W'(front_i.nmag[3]);
            q01_reg <= PAIR_W'(front_i.qmag[0]) * PAIR_W'(front_i.qmag[1]);
            q23_reg <= PAIR_W'(front_i.qmag[2]) * PAIR_W'(front_i.qmag[3]);
            q45_reg <= PAIR_W'(front_i.qmag[4]) * PAIR_W'(front_i.qmag[5]);
            // numerator, four denominator factors
            m2_reg   <= m1_reg;
            nn2_reg  <= PROD_W'(n02_reg) * PROD_W'(n13_reg);
            qa_reg   <= PROD_W'(q01_reg) * PROD_W'(q23_reg);
            q45b_reg <= q45_reg;
            // last factor pair split over two half products
            m3_reg   <= m2_reg;
            nn3_reg  <= nn2_reg;
            qlo_reg  <= PROD_W'(qa_reg[PAIR_W-1:0]) * PROD_W'(q45b_reg);
            qhi_reg  <= PROD_W'(qa_reg[PROD_W-1:PAIR_W]) * PROD_W'(q45b_reg);
            // recombine
            m4_reg  <= m3_reg;
            nn4_reg <= nn3_reg;
            q_reg   <= {qhi_reg, {PAIR_W{1'b0}}} + Q_W'(qlo_reg);
        end
    end

    always_comb begin
        q4_full            = {q_reg, 2'b00};
        lane_next.valid    = v_reg[3];
        lane_next.meta     = m4_reg;
        lane_next.meta.sat = ((Q_W+2)'(nn4_reg) >= q4_full);
        lane_next.x        = X_W'({nn4_reg, 2'b00});
        lane_next.m        = '0;
        lane_next.u        = '0;
        lane_next.q4       = Q4_W'(q4_full);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (adv) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

// File: hw/rtl/w6j_cell.sv
// One root-digit cell: resolves one result bit against the scaled remainder
`timescale 1ns / 1ps
module w6j_cell import w6j_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  adv,
    input  lane_t lane_i,
    output lane_t lane_o
);

    logic [X_W-1:0] trial, diff;
    logic           take;
    lane_t          lane_next, lane_reg;

    always_comb begin
        // trial = Q4 * (4u + 1), remainder kept scaled by 4^-k
        trial     = X_W'({lane_i.m, 2'b00}) + X_W'(lane_i.q4);
        take      = (lane_i.x >= trial);
        diff      = lane_i.x - trial;
        lane_next = lane_i;
        if (take) begin
            lane_next.x = {diff[X_W-3:0], 2'b00};
            lane_next.m = {lane_i.m[M_W-2:0], 1'b0} + M_W'(lane_i.q4);
        end else begin
            lane_next.x = {lane_i.x[X_W-3:0], 2'b00};
            lane_next.m = {lane_i.m[M_W-2:0], 1'b0};
        end
        lane_next.u = {lane_i.u[ROOT_BITS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_reg.valid <= 1'b0;
        end else if (adv) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

// File: hw/rtl/wigner_6j_unit_argument_evaluator_top.sv
// Top level of the 6j unit-argument evaluator: front, products, root cells, output
//
//  channel   dir   beat contents
//  s_        in    tdata[9:0] mom_a, [19:10] mom_b, [29:20] mom_c, [39:30] mom_d,
//                  [49:40] mom_f
//  m_        out   tdata[31:0] symbol_value (Q1.30), tuser[1:0] status
//
// One beat in and one beat out per cycle while m_ is not stalled; an accepted beat
// passes 38 register stages (front 1, products 5, 31 root cells, output register 1).
// The root cell row sets the latency.
// aresetn clears all stage valid bits; payload registers are not reset.
// A stall on m_ freezes the whole pipe; s_tready follows !m_tvalid || m_tready.
`timescale 1ns / 1ps
module wigner_6j_unit_argument_evaluator_top import w6j_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // mom_a, mom_b, mom_c, mom_d, mom_f, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // symbol_value
    output logic [1:0]  m_tuser    // status
);

    logic   adv;
    front_t front;
    lane_t  chain [ROOT_BITS+1];
    logic [ROOT_BITS:0]   rsum;
    logic [ROOT_BITS-1:0] rmag;
    logic [VAL_W-1:0]     val_next, val_reg;
    status_t              st_reg;
    logic                 ov_reg;
    lane_t                last;

    assign adv      = !ov_reg || m_tready;
    assign s_tready = adv;

    w6j_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .mom_a    (s_tdata[9:0]),
        .mom_b    (s_tdata[19:10]),
        .mom_c    (s_tdata[29:20]),
        .mom_d    (s_tdata[39:30]),
        .mom_f    (s_tdata[49:40]),
        .front_o  (front)
    );

    w6j_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .front_i (front),
        .lane_o  (chain[0])
    );

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_cell
        w6j_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .lane_i  (chain[g]),
            .lane_o  (chain[g+1])
        );
    end

    always_comb begin
        last = chain[ROOT_BITS];
        // round half up on the extra root bit, clamp at one
        rsum = {1'b0, last.u} + (ROOT_BITS+1)'(1);
        rmag = last.meta.sat ? ROOT_BITS'(1 << FRAC_BITS) : rsum[ROOT_BITS:1];
        if (last.meta.zero)
            val_next = '0;
        else if (last.meta.neg)
            val_next = -VAL_W'(rmag);
        else
            val_next = VAL_W'(rmag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (adv) begin
            ov_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            val_reg <= val_next;
            st_reg  <= last.meta.status;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = val_reg;
    assign m_tuser  = st_reg;

`include "assert_macros.svh"

    `ASSERT_CLK(a_status_code, m_tvalid |-> (m_tuser != 2'd3), "status code out of range")
    `ASSERT_CLK(a_zero_on_error, (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0),
        "nonzero value with error status")
    `ASSERT_CLK(a_mag_bound, m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824 &&
        $signed(m_tdata) >= -32'sd1073741824), "value beyond plus or minus one")
    `ASSERT_CLK(a_ready_rule, s_tready == (!m_tvalid || m_tready), "ready mismatch")
    `ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
